FILE: design/pfe_pkg.sv
// Shared types, codes and constants of the printf format engine.
package pfe_pkg;

  localparam int BUFFER_CAPACITY_DEF = 128;
  localparam int MAX_PAD_WIDTH_DEF   = 32;
  localparam int DIGITS              = 24;
  localparam int IDX_W               = $clog2(DIGITS);

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_C = 8'h63;
  localparam logic [7:0] CH_LOW_D = 8'h64;
  localparam logic [7:0] CH_LOW_H = 8'h68;
  localparam logic [7:0] CH_LOW_I = 8'h69;
  localparam logic [7:0] CH_LOW_L = 8'h6c;
  localparam logic [7:0] CH_LOW_O = 8'h6f;
  localparam logic [7:0] CH_LOW_P = 8'h70;
  localparam logic [7:0] CH_LOW_U = 8'h75;
  localparam logic [7:0] CH_LOW_X = 8'h78;

  typedef enum logic [3:0] {
    S_IDLE, S_ONE, S_TERM, S_CONV, S_SCAN, S_SIGN, S_PRE0, S_PREX, S_PAD, S_DIG
  } state_t;

  typedef enum logic [2:0] { LM_NONE, LM_L, LM_LL, LM_H, LM_HH } lmod_t;
  typedef enum logic [1:0] { W8, W16, W32, W64 } wsel_t;
  typedef enum logic [1:0] { BASE_DEC, BASE_HEX, BASE_OCT } base_t;
  typedef enum logic [1:0] { ACT_NONE, ACT_ONE, ACT_NUM, ACT_TERM } act_t;

  typedef struct packed {
    logic       load;
    wsel_t      wsel;
    logic       sgn;
    base_t      base;
    logic       prefix;
    logic [5:0] pad_w;
    logic       conv;
    logic       scan;
    logic       emit;
    logic       emit_digit;
    logic [7:0] lit;
    logic       last;
    logic       term;
    logic       term_err;
    logic       pad_dec;
    logic       idx_dec;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic conv_done;
    logic scan_done;
    logic neg;
    logic prefix;
    logic pad_zero;
    logic idx_zero;
  } sts_t;

endpackage

FILE: design/pfe_ctrl.sv
// Format parser and sequencing state machine of the printf format engine.
module pfe_ctrl #(
  parameter int MAX_PAD_WIDTH = pfe_pkg::MAX_PAD_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    fmt_char,
  input  logic [7:0]    arg_lo,
  input  pfe_pkg::sts_t sts,
  output pfe_pkg::cmd_t cmd
);

  localparam logic [7:0] CH0 = pfe_pkg::CH_ZERO;

  pfe_pkg::state_t state, state_next;
  pfe_pkg::lmod_t  lmod, lmod_next;
  pfe_pkg::act_t   act;
  pfe_pkg::wsel_t  d_wsel;
  pfe_pkg::base_t  d_base;
  logic       in_spec, in_spec_next;
  logic       has_content, has_content_next;
  logic       zero_pad, zero_pad_next;
  logic [5:0] pad_width, pad_width_next;
  logic       err, err_next;
  logic       term_err;
  logic [7:0] lit_char, d_lit;
  logic       d_sgn, d_prefix;
  logic [8:0] wsum;
  logic       accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != pfe_pkg::S_IDLE);
  assign wsum = {pad_width, 3'b000} + {2'b00, pad_width, 1'b0} + {1'b0, fmt_char - CH0};

  // Decode of one format character against the current spec state.
  always_comb begin
    act              = pfe_pkg::ACT_NONE;
    d_lit            = fmt_char;
    d_wsel           = pfe_pkg::W32;
    d_base           = pfe_pkg::BASE_DEC;
    d_sgn            = 1'b0;
    d_prefix         = 1'b0;
    in_spec_next     = in_spec;
    has_content_next = has_content;
    zero_pad_next    = zero_pad;
    pad_width_next   = pad_width;
    lmod_next        = lmod;
    err_next         = err;
    if (fmt_char == pfe_pkg::CH_NUL) begin
      act              = pfe_pkg::ACT_TERM;
      in_spec_next     = 1'b0;
      has_content_next = 1'b0;
      zero_pad_next    = 1'b0;
      pad_width_next   = '0;
      lmod_next        = pfe_pkg::LM_NONE;
      err_next         = 1'b0;
    end else if (err) begin
      act = pfe_pkg::ACT_NONE;
    end else if (!in_spec) begin
      if (fmt_char == pfe_pkg::CH_PCT) begin
        in_spec_next     = 1'b1;
        has_content_next = 1'b0;
      end else begin
        act = pfe_pkg::ACT_ONE;
      end
    end else begin
      // Every path below either keeps the spec open or closes it.
      in_spec_next     = 1'b0;
      has_content_next = 1'b0;
      zero_pad_next    = 1'b0;
      pad_width_next   = '0;
      lmod_next        = pfe_pkg::LM_NONE;
      if (fmt_char inside {[pfe_pkg::CH_ZERO:pfe_pkg::CH_NINE]}) begin
        if (lmod != pfe_pkg::LM_NONE || (fmt_char != pfe_pkg::CH_ZERO && !zero_pad)) begin
          err_next = 1'b1;
        end else begin
          in_spec_next     = 1'b1;
          has_content_next = 1'b1;
          zero_pad_next    = 1'b1;
          lmod_next        = lmod;
          pad_width_next   = pad_width;
          if (zero_pad) begin
            pad_width_next = (wsum > 9'(MAX_PAD_WIDTH)) ? 6'(MAX_PAD_WIDTH) : wsum[5:0];
          end
        end
      end else begin
        case (fmt_char)
          pfe_pkg::CH_PCT: begin
            if (has_content) begin
              err_next = 1'b1;
            end else begin
              act = pfe_pkg::ACT_ONE;
            end
          end
          pfe_pkg::CH_LOW_L, pfe_pkg::CH_LOW_H: begin
            if (lmod == pfe_pkg::LM_NONE) begin
              lmod_next = (fmt_char == pfe_pkg::CH_LOW_L) ? pfe_pkg::LM_L : pfe_pkg::LM_H;
            end else if (lmod == pfe_pkg::LM_L && fmt_char == pfe_pkg::CH_LOW_L) begin
              lmod_next = pfe_pkg::LM_LL;
            end else if (lmod == pfe_pkg::LM_H && fmt_char == pfe_pkg::CH_LOW_H) begin
              lmod_next = pfe_pkg::LM_HH;
            end else begin
              err_next = 1'b1;
            end
            if (!err_next) begin
              in_spec_next     = 1'b1;
              has_content_next = 1'b1;
              zero_pad_next    = zero_pad;
              pad_width_next   = pad_width;
            end
          end
          pfe_pkg::CH_LOW_C: begin
            if (lmod != pfe_pkg::LM_NONE || (zero_pad && pad_width != '0)) begin
              err_next = 1'b1;
            end else begin
              act   = pfe_pkg::ACT_ONE;
              d_lit = arg_lo;
            end
          end
          pfe_pkg::CH_LOW_P: begin
            if (lmod != pfe_pkg::LM_NONE) begin
              err_next = 1'b1;
            end else begin
              act      = pfe_pkg::ACT_NUM;
              d_base   = pfe_pkg::BASE_HEX;
              d_prefix = 1'b1;
            end
          end
          pfe_pkg::CH_LOW_D, pfe_pkg::CH_LOW_I, pfe_pkg::CH_LOW_U,
          pfe_pkg::CH_LOW_X, pfe_pkg::CH_LOW_O: begin
            act   = pfe_pkg::ACT_NUM;
            d_sgn = (fmt_char == pfe_pkg::CH_LOW_D) || (fmt_char == pfe_pkg::CH_LOW_I);
            if (fmt_char == pfe_pkg::CH_LOW_X) begin
              d_base = pfe_pkg::BASE_HEX;
            end else if (fmt_char == pfe_pkg::CH_LOW_O) begin
              d_base = pfe_pkg::BASE_OCT;
            end
            case (lmod)
              pfe_pkg::LM_LL: d_wsel = pfe_pkg::W64;
              pfe_pkg::LM_H:  d_wsel = pfe_pkg::W16;
              pfe_pkg::LM_HH: d_wsel = pfe_pkg::W8;
              default:        d_wsel = pfe_pkg::W32;
            endcase
          end
          default: err_next = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pfe_pkg::S_IDLE;
      in_spec     <= 1'b0;
      has_content <= 1'b0;
      zero_pad    <= 1'b0;
      pad_width   <= '0;
      lmod        <= pfe_pkg::LM_NONE;
      err         <= 1'b0;
      term_err    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        in_spec     <= in_spec_next;
        has_content <= has_content_next;
        zero_pad    <= zero_pad_next;
        pad_width   <= pad_width_next;
        lmod        <= lmod_next;
        err         <= err_next;
        term_err    <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lit_char <= (fmt_char == pfe_pkg::CH_PCT) ? pfe_pkg::CH_PCT : d_lit;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pfe_pkg::S_IDLE: begin
        if (accept) begin
          case (act)
            pfe_pkg::ACT_ONE:  state_next = pfe_pkg::S_ONE;
            pfe_pkg::ACT_NUM:  state_next = pfe_pkg::S_CONV;
            pfe_pkg::ACT_TERM: state_next = pfe_pkg::S_TERM;
            default:           state_next = pfe_pkg::S_IDLE;
          endcase
        end
      end
      pfe_pkg::S_ONE, pfe_pkg::S_TERM: begin
        if (sts.slot_free) state_next = pfe_pkg::S_IDLE;
      end
      pfe_pkg::S_CONV: begin
        if (sts.conv_done) state_next = pfe_pkg::S_SCAN;
      end
      pfe_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.neg) state_next = pfe_pkg::S_SIGN;
          else if (sts.prefix) state_next = pfe_pkg::S_PRE0;
          else state_next = pfe_pkg::S_PAD;
        end
      end
      pfe_pkg::S_SIGN: begin
        if (sts.slot_free) state_next = sts.prefix ? pfe_pkg::S_PRE0 : pfe_pkg::S_PAD;
      end
      pfe_pkg::S_PRE0: begin
        if (sts.slot_free) state_next = pfe_pkg::S_PREX;
      end
      pfe_pkg::S_PREX: begin
        if (sts.slot_free) state_next = pfe_pkg::S_PAD;
      end
      pfe_pkg::S_PAD: begin
        if (sts.pad_zero) state_next = pfe_pkg::S_DIG;
      end
      pfe_pkg::S_DIG: begin
        if (sts.slot_free && sts.idx_zero) state_next = pfe_pkg::S_IDLE;
      end
      default: state_next = pfe_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd          = '0;
    cmd.wsel     = d_wsel;
    cmd.sgn      = d_sgn;
    cmd.base     = d_base;
    cmd.prefix   = d_prefix;
    cmd.pad_w    = zero_pad ? pad_width : 6'd0;
    cmd.term_err = term_err;
    case (state)
      pfe_pkg::S_IDLE: cmd.load = accept && (act == pfe_pkg::ACT_NUM);
      pfe_pkg::S_ONE: begin
        cmd.emit = sts.slot_free;
        cmd.lit  = lit_char;
        cmd.last = 1'b1;
      end
      pfe_pkg::S_TERM: cmd.term = sts.slot_free;
      pfe_pkg::S_CONV: cmd.conv = 1'b1;
      pfe_pkg::S_SCAN: cmd.scan = 1'b1;
      pfe_pkg::S_SIGN: begin
        cmd.emit = sts.slot_free;
        cmd.lit  = pfe_pkg::CH_MINUS;
      end
      pfe_pkg::S_PRE0: begin
        cmd.emit = sts.slot_free;
        cmd.lit  = pfe_pkg::CH_ZERO;
      end
      pfe_pkg::S_PREX: begin
        cmd.emit = sts.slot_free;
        cmd.lit  = pfe_pkg::CH_LOW_X;
      end
      pfe_pkg::S_PAD: begin
        cmd.emit    = sts.slot_free && !sts.pad_zero;
        cmd.pad_dec = sts.slot_free && !sts.pad_zero;
        cmd.lit     = pfe_pkg::CH_ZERO;
      end
      pfe_pkg::S_DIG: begin
        cmd.emit       = sts.slot_free;
        cmd.emit_digit = 1'b1;
        cmd.last       = sts.idx_zero;
        cmd.idx_dec    = sts.slot_free && !sts.idx_zero;
      end
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

FILE: design/pfe_dpath.sv
// Number conversion, digit store, length counters and output register.
module pfe_dpath #(
  parameter int BUFFER_CAPACITY = pfe_pkg::BUFFER_CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  pfe_pkg::cmd_t cmd,
  output pfe_pkg::sts_t sts,
  input  logic [63:0]   arg_value,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          char_valid,
  output logic          kept,
  output logic          run_last,
  output logic          end_of_string,
  output logic          error_flag,
  output logic [15:0]   total_len
);

  localparam int ND = pfe_pkg::DIGITS;
  localparam int IW = pfe_pkg::IDX_W;

  logic [ND-1:0][3:0] digit_store, dig_load, dig_adj;
  logic [63:0]     value, mask, masked, mag, aligned;
  logic [ND*4-1:0] vz;
  logic [6:0]      shift_cnt, bits;
  logic [IW-1:0]   idx;
  logic [5:0]      pad_cnt, n_digits, pads, pad_req;
  logic            neg, prefix, sbit, neg_d;
  logic [7:0]      stored_count;
  logic [15:0]     produced_count, produced_inc;
  logic [3:0]      cur_digit;
  logic [7:0]      digit_char;
  logic            keep_now;

  // Masking, sign and magnitude of the argument at load.
  always_comb begin
    case (cmd.wsel)
      pfe_pkg::W8:  begin mask = 64'h0000_0000_0000_00ff; bits = 7'd8;  end
      pfe_pkg::W16: begin mask = 64'h0000_0000_0000_ffff; bits = 7'd16; end
      pfe_pkg::W64: begin mask = '1;                     bits = 7'd64; end
      default:      begin mask = 64'h0000_0000_ffff_ffff; bits = 7'd32; end
    endcase
    masked = arg_value & mask;
    case (cmd.wsel)
      pfe_pkg::W8:  sbit = masked[7];
      pfe_pkg::W16: sbit = masked[15];
      pfe_pkg::W64: sbit = masked[63];
      default:      sbit = masked[31];
    endcase
    neg_d = cmd.sgn && sbit;
    mag   = neg_d ? ((~masked + 64'd1) & mask) : masked;
    case (cmd.wsel)
      pfe_pkg::W8:  aligned = mag << 56;
      pfe_pkg::W16: aligned = mag << 48;
      pfe_pkg::W64: aligned = mag;
      default:      aligned = mag << 32;
    endcase
    vz = {{(ND*4-64){1'b0}}, masked};
    for (int i = 0; i < ND; i++) begin
      case (cmd.base)
        pfe_pkg::BASE_HEX: dig_load[i] = vz[4*i +: 4];
        pfe_pkg::BASE_OCT: dig_load[i] = {1'b0, vz[3*i +: 3]};
        default:           dig_load[i] = 4'd0;
      endcase
    end
  end

  // Add-three correction of the binary to decimal shift.
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      dig_adj[i] = (digit_store[i] >= 4'd5) ? digit_store[i] + 4'd3 : digit_store[i];
    end
  end

  assign cur_digit  = digit_store[idx];
  assign digit_char = (cur_digit < 4'd10) ? pfe_pkg::CH_ZERO + {4'd0, cur_digit}
                                          : pfe_pkg::CH_LOW_A + {4'd0, cur_digit - 4'd10};
  assign n_digits   = {1'b0, idx} + 6'd1;
  assign pads       = (pad_req > n_digits) ? pad_req - n_digits : 6'd0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg         <= neg_d;
      prefix      <= cmd.prefix;
      pad_req     <= cmd.pad_w;
      value       <= aligned;
      digit_store <= dig_load;
      shift_cnt   <= (cmd.base == pfe_pkg::BASE_DEC) ? bits : 7'd0;
      idx         <= IW'(ND - 1);
    end else if (cmd.conv && shift_cnt != 7'd0) begin
      digit_store[0] <= {dig_adj[0][2:0], value[63]};
      for (int i = 1; i < ND; i++) begin
        digit_store[i] <= {dig_adj[i][2:0], dig_adj[i-1][3]};
      end
      value     <= value << 1;
      shift_cnt <= shift_cnt - 7'd1;
    end else if (cmd.scan) begin
      if (sts.scan_done) begin
        pad_cnt <= pads;
      end else begin
        idx <= idx - IW'(1);
      end
    end else if (cmd.pad_dec) begin
      pad_cnt <= pad_cnt - 6'd1;
    end else if (cmd.idx_dec) begin
      idx <= idx - IW'(1);
    end
  end

  assign keep_now     = stored_count < 8'(BUFFER_CAPACITY);
  assign produced_inc = (produced_count != 16'hffff) ? produced_count + 16'd1 : produced_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      stored_count   <= '0;
      produced_count <= '0;
    end else begin
      if (cmd.emit || cmd.term) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        if (keep_now) stored_count <= stored_count + 8'd1;
        produced_count <= produced_inc;
      end else if (cmd.term) begin
        produced_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char      <= cmd.emit_digit ? digit_char : cmd.lit;
      char_valid    <= 1'b1;
      kept          <= keep_now;
      run_last      <= cmd.last;
      end_of_string <= 1'b0;
      error_flag    <= 1'b0;
      total_len     <= produced_inc;
    end else if (cmd.term) begin
      out_char      <= pfe_pkg::CH_NUL;
      char_valid    <= 1'b0;
      kept          <= 1'b0;
      run_last      <= 1'b1;
      end_of_string <= 1'b1;
      error_flag    <= cmd.term_err;
      total_len     <= produced_count;
    end
  end

  always_comb begin
    sts.slot_free = !out_valid || !out_stall;
    sts.conv_done = (shift_cnt == 7'd0);
    sts.scan_done = (idx == '0) || (cur_digit != 4'd0);
    sts.neg       = neg;
    sts.prefix    = prefix;
    sts.pad_zero  = (pad_cnt == 6'd0);
    sts.idx_zero  = (idx == '0);
  end

endmodule

FILE: design/printf_format_engine.sv
// Top level of the printf format engine: parser controller plus conversion datapath.
//
//   channel | handshake            | payload                                  | dir
//   --------+----------------------+------------------------------------------+----
//   request | in_valid, in_stall   | fmt_char, arg_value                      | in
//   result  | out_valid, out_stall | out_char .. total_len (seven fields)     | out
//
// One request is taken at a time; a plain character, "%%", "%c" or the terminator
// waits in S_ONE or S_TERM for room in the result register, and a spec character
// that produces nothing is accepted without leaving idle. A number passes the load,
// the conversion (a shift per argument bit for decimal), a scan past the leading zero
// slots of the 24-entry digit store and the emitting states, held by a result stall.
// Reset is synchronous and clears the parser state, the counters and the result valid
// flag; a stalled result holds while the next request is already accepted.
module printf_format_engine #(
  parameter int BUFFER_CAPACITY = pfe_pkg::BUFFER_CAPACITY_DEF,
  parameter int MAX_PAD_WIDTH   = pfe_pkg::MAX_PAD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  fmt_char,
  input  logic [63:0] arg_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        char_valid,
  output logic        kept,
  output logic        run_last,
  output logic        end_of_string,
  output logic        error_flag,
  output logic [15:0] total_len
);

  pfe_pkg::cmd_t cmd;
  pfe_pkg::sts_t sts;

  // The controller parses the format and sequences each conversion.
  pfe_ctrl #(
    .MAX_PAD_WIDTH(MAX_PAD_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .fmt_char (fmt_char),
    .arg_lo   (arg_value[7:0]),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the digits, the length counters and the result register.
  pfe_dpath #(
    .BUFFER_CAPACITY(BUFFER_CAPACITY)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .arg_value     (arg_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .char_valid    (char_valid),
    .kept          (kept),
    .run_last      (run_last),
    .end_of_string (end_of_string),
    .error_flag    (error_flag),
    .total_len     (total_len)
  );

`ifndef SYNTH
  // A character is only written into the result register when it has room.
  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.term) |-> sts.slot_free)
    else $error("result written while the output register was full");

  // Nothing is emitted while the block is open for a new request.
  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !(cmd.emit || cmd.term))
    else $error("result produced while accepting a request");

  // The terminator result closes its request and carries no character.
  a_term_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_string) |-> (run_last && !char_valid && !kept))
    else $error("malformed terminator result");
`endif

endmodule
